### hw/rtl/ultlc_pkg.sv
// ============================================================================
// ultlc_pkg
// Shared types, codes and calendar helpers for the Unix time to local
// calendar converter.
// ============================================================================
package ultlc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUMMER = 1'd1;

  // Summer time modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_EU   = 2'd1;
  localparam logic [1:0] MODE_US   = 2'd2;

  localparam int unsigned OUT_DATA_W = 48;
  localparam logic [11:0] EPOCH_YEAR = 12'd1970;
  localparam logic [3:0]  MONTH_MAR  = 4'd2;   // zero based month index
  localparam logic [3:0]  MONTH_OCT  = 4'd9;
  localparam logic [3:0]  MONTH_DEC  = 4'd11;

  // Operations of the shared constant divider
  typedef logic [2:0] div_op_t;
  localparam div_op_t OP_SEC = 3'd0;  // t      / 60
  localparam div_op_t OP_MIN = 3'd1;  // t/60   / 60
  localparam div_op_t OP_HR  = 3'd2;  // t/3600 / 24
  localparam div_op_t OP_WD  = 3'd3;  // (days + 4) mod 7
  localparam div_op_t OP_Y5A = 3'd4;  // (5y/4 + 4) mod 7
  localparam div_op_t OP_Y5B = 3'd5;  // (5y/4 + 1) mod 7

  localparam int unsigned DIV_CNT_W = 1;  // product step, then quotient and remainder

  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    div_step;
    div_op_t div_op;
    logic    year_step;
    logic    month_step;
    logic    rule_apply;
    logic    out_load;
  } ultlc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_fit;
    logic month_stop;
    logic summer_hit;
  } ultlc_sts_t;

  // Valid over 1970..2200, which covers the span the year walk can reach
  function automatic logic is_leap(input logic [11:0] year);
    is_leap = (year[1:0] == 2'd0) && (year != 12'd2100) && (year != 12'd2200);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (m)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/ultlc_dp.sv
// ============================================================================
// ultlc_dp
// Datapath: zone shift, reciprocal constant divider, year and month walk,
// summer time rule and the output register.
// ============================================================================
module ultlc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [31:0]                          in_data_i,
  input  logic [6:0]                           zone_i,
  input  ultlc_pkg::ultlc_cmd_t                cmd_i,
  output ultlc_pkg::ultlc_sts_t                sts_o,
  output logic [ultlc_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                 out_user_o
);

  logic [31:0] t_q;
  logic [31:0] dq_q;
  logic [63:0] prod_q;
  logic [ultlc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q;
  logic [15:0] days_q;
  logic [2:0]  wday_q, ra_q, rb_q;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic        applied_q;
  logic [ultlc_pkg::OUT_DATA_W-1:0] out_data_q;
  logic        out_user_q;

  logic signed [16:0] zone_off;
  logic [6:0]  divisor;
  logic [31:0] recip;
  logic [31:0] div_src;
  logic [31:0] quo;
  logic [7:0]  qd_lo;
  logic [7:0]  rem_n;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mlen;
  logic [13:0] y5;
  logic [4:0]  day;
  logic [9:0]  hd, thr_mar, thr_oct;

  assign zone_off = 17'(signed'(zone_i)) * 17'sd900;

  // Quotient = (n * ceil(2^s / d)) >> s, exact over the operand ranges used
  always_comb begin
    divisor = 7'd7;
    recip   = 32'd0;
    div_src = 32'd0;
    quo     = 32'd0;
    unique case (cmd_i.div_op)
      ultlc_pkg::OP_SEC: begin
        divisor = 7'd60;
        recip   = 32'h8888_8889;
        div_src = t_q;
        quo     = {5'd0, prod_q[63:37]};
      end
      ultlc_pkg::OP_MIN: begin
        divisor = 7'd60;
        recip   = 32'h8888_8889;
        div_src = dq_q;
        quo     = {5'd0, prod_q[63:37]};
      end
      ultlc_pkg::OP_HR: begin
        divisor = 7'd24;
        recip   = 32'hAAAA_AAAB;
        div_src = dq_q;
        quo     = {4'd0, prod_q[63:36]};
      end
      ultlc_pkg::OP_WD: begin
        divisor = 7'd7;
        recip   = 32'h9249_2493;
        div_src = 32'(days_q) + 32'd4;
        quo     = {2'd0, prod_q[63:34]};
      end
      ultlc_pkg::OP_Y5A: begin
        divisor = 7'd7;
        recip   = 32'h9249_2493;
        div_src = 32'(y5) + 32'd4;
        quo     = {2'd0, prod_q[63:34]};
      end
      ultlc_pkg::OP_Y5B: begin
        divisor = 7'd7;
        recip   = 32'h9249_2493;
        div_src = 32'(y5) + 32'd1;
        quo     = {2'd0, prod_q[63:34]};
      end
      default: begin
        divisor = 7'd7;
        recip   = 32'd0;
        div_src = 32'd0;
        quo     = 32'd0;
      end
    endcase
  end

  // Remainder is below 64, so the low byte of n - q*d is exact
  assign qd_lo = quo[7:0] * {1'b0, divisor};
  assign rem_n = dq_q[7:0] - qd_lo;

  assign leap     = ultlc_pkg::is_leap(year_q);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mlen     = ultlc_pkg::month_len(month_q, leap);

  // 5*y/4 and the last-Sunday hour thresholds
  assign y5      = (({2'b00, year_q} << 2) + {2'b00, year_q}) >> 2;
  assign day     = days_q[4:0] + 5'd1;
  assign hd      = 10'(hour_q) + (10'(day) << 4) + (10'(day) << 3);
  assign thr_mar = 10'd3 + (10'(5'd31 - 5'(ra_q)) << 4) + (10'(5'd31 - 5'(ra_q)) << 3);
  assign thr_oct = 10'd3 + (10'(5'd31 - 5'(rb_q)) << 4) + (10'(5'd31 - 5'(rb_q)) << 3);

  always_comb begin
    sts_o.div_last   = (cnt_q == '1);
    sts_o.year_fit   = days_q < 16'(year_len);
    sts_o.month_stop = (days_q < 16'(mlen)) || (month_q == ultlc_pkg::MONTH_DEC);
    priority if (month_q > ultlc_pkg::MONTH_MAR && month_q < ultlc_pkg::MONTH_OCT) begin
      sts_o.summer_hit = 1'b1;
    end else if (month_q == ultlc_pkg::MONTH_MAR) begin
      sts_o.summer_hit = hd >= thr_mar;
    end else if (month_q == ultlc_pkg::MONTH_OCT) begin
      sts_o.summer_hit = hd < thr_oct;
    end else begin
      sts_o.summer_hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q       <= in_data_i + 32'(zone_off);
      applied_q <= 1'b0;
    end
    if (cmd_i.rule_apply) begin
      t_q       <= t_q + 32'd3600;
      applied_q <= 1'b1;
    end
    if (cmd_i.div_start) begin
      dq_q <= div_src;
      if (cmd_i.div_op == ultlc_pkg::OP_SEC) begin
        year_q  <= ultlc_pkg::EPOCH_YEAR;
        month_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      if (sts_o.div_last) begin
        dq_q <= quo;
        unique case (cmd_i.div_op)
          ultlc_pkg::OP_SEC: sec_q <= rem_n[5:0];
          ultlc_pkg::OP_MIN: min_q <= rem_n[5:0];
          ultlc_pkg::OP_HR: begin
            hour_q <= rem_n[4:0];
            days_q <= quo[15:0];
          end
          ultlc_pkg::OP_WD:  wday_q <= rem_n[2:0] + 3'd1;
          ultlc_pkg::OP_Y5A: ra_q   <= rem_n[2:0];
          ultlc_pkg::OP_Y5B: rb_q   <= rem_n[2:0];
          default: ;
        endcase
      end else begin
        prod_q <= 64'(dq_q) * 64'(recip);
      end
    end
    if (cmd_i.year_step && !sts_o.year_fit) begin
      days_q <= days_q - 16'(year_len);
      year_q <= year_q + 12'd1;
    end
    if (cmd_i.month_step && !(days_q < 16'(mlen))) begin
      days_q <= days_q - 16'(mlen);
      if (month_q != ultlc_pkg::MONTH_DEC) begin
        month_q <= month_q + 4'd1;
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= {7'd0, sec_q, min_q, hour_q, wday_q, day, month_q + 4'd1, year_q};
      out_user_q <= applied_q;
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

### hw/rtl/ultlc_ctrl.sv
// ============================================================================
// ultlc_ctrl
// Controller: sequences the divider passes, the year and month walk, the
// summer time decision and the hand-off to the output register.
// ============================================================================
module ultlc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  logic [1:0]             mode_i,
  input  ultlc_pkg::ultlc_sts_t  sts_i,
  output ultlc_pkg::ultlc_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DSTART = 3'd1;
  localparam logic [2:0] ST_DRUN   = 3'd2;
  localparam logic [2:0] ST_YEAR   = 3'd3;
  localparam logic [2:0] ST_MONTH  = 3'd4;
  localparam logic [2:0] ST_RULE   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0] state_q, state_d;
  ultlc_pkg::div_op_t op_q, op_d;
  logic pass_q, pass_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pass_d      = pass_q;
    cmd_o       = '0;
    cmd_o.div_op = op_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = ultlc_pkg::OP_SEC;
          pass_d     = 1'b0;
          state_d    = ST_DSTART;
        end
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DRUN;
      end
      ST_DRUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          unique case (op_q)
            ultlc_pkg::OP_SEC: begin op_d = ultlc_pkg::OP_MIN; state_d = ST_DSTART; end
            ultlc_pkg::OP_MIN: begin op_d = ultlc_pkg::OP_HR;  state_d = ST_DSTART; end
            ultlc_pkg::OP_HR:  begin op_d = ultlc_pkg::OP_WD;  state_d = ST_DSTART; end
            ultlc_pkg::OP_WD:  state_d = ST_YEAR;
            ultlc_pkg::OP_Y5A: begin op_d = ultlc_pkg::OP_Y5B; state_d = ST_DSTART; end
            ultlc_pkg::OP_Y5B: state_d = ST_RULE;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (sts_i.year_fit) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (sts_i.month_stop) begin
          if (!pass_q && mode_i == ultlc_pkg::MODE_EU) begin
            op_d    = ultlc_pkg::OP_Y5A;
            state_d = ST_DSTART;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RULE: begin
        // Summer hour added: decode the shifted time once more
        if (sts_i.summer_hit) begin
          cmd_o.rule_apply = 1'b1;
          pass_d           = 1'b1;
          op_d             = ultlc_pkg::OP_SEC;
          state_d          = ST_DSTART;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= ultlc_pkg::OP_SEC;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/unix_time_to_local_calendar.sv
// The time is taken apart by one shared constant divider that multiplies
// by a reciprocal: four passes per decode (60, 60, 24, weekday mod 7),
// then one step per year since 1970 and per month; European mode adds two
// mod 7 passes for the last-Sunday rule and, when summer time applies, a
// second decode of the shifted time. One item is in work at a time; a
// finished result sits in the output register, so the next item can be
// taken while it waits.
// ============================================================================
// unix_time_to_local_calendar
// Unix seconds to local Gregorian date and time with zone offset and
// European summer time.
// ============================================================================
module unix_time_to_local_calendar (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [31:0]                           s_axis_tdata,   // [31:0] utc_seconds
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [11:0] year_full, [15:12] month_num, [20:16] day_of_month,
  // [23:21] weekday_num, [28:24] hour_num, [34:29] minute_num,
  // [40:35] second_num, [47:41] zero
  output logic [ultlc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tuser,   // [0] summer_applied
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ultlc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ultlc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic [6:0] zone_q;
  logic [1:0] mode_q;
  ultlc_pkg::ultlc_cmd_t cmd;
  ultlc_pkg::ultlc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      mode_q <= ultlc_pkg::MODE_NONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ultlc_pkg::CFG_ZONE:   zone_q <= cfg_data_i[6:0];
        ultlc_pkg::CFG_SUMMER: mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ultlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mode_i      (mode_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ultlc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .zone_i     (zone_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule

### hw/rtl/ultlc_checker.sv
// ============================================================================
// ultlc_checker
// Port-level checks on the calendar converter, bound to the top level.
// ============================================================================
module ultlc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [ultlc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tuser
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // One item in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:12] != 4'd0) && (m_axis_tdata[15:12] <= 4'd12) &&
      (m_axis_tdata[20:16] != 5'd0) && (m_axis_tdata[23:21] != 3'd0))
    else $error("month, day or weekday out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[28:24] < 5'd24) && (m_axis_tdata[34:29] < 6'd60) &&
      (m_axis_tdata[40:35] < 6'd60))
    else $error("hour, minute or second out of range");

endmodule

bind unix_time_to_local_calendar ultlc_checker u_ultlc_checker (.*);
